// File: sv/pngu_pkg.sv
// ----------------------------------------------------------------------------
// Pink noise generator package
// Shared types, register codes and the random shift register step.
// ----------------------------------------------------------------------------
package pngu_pkg;

	localparam int SAMPLE_W = 16;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;
	localparam int AMP_W    = 15;
	localparam int GCNT_W   = 6;
	localparam int MODE_W   = 2;

	localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

	localparam logic [AMP_W-1:0]  AMP_RST  = 15'd3276;
	localparam logic [GCNT_W-1:0] GCNT_RST = 6'd25;
	localparam logic [31:0]       SEED_RST = 32'd1;

	typedef enum logic [MODE_W-1:0] {
		MODE_VOSS  = 2'd0,
		MODE_VM    = 2'd1,
		MODE_WHITE = 2'd2,
		MODE_ALT   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_MODE = 2'd0,
		REG_AMP  = 2'd1,
		REG_GCNT = 2'd2,
		REG_SEED = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAW,
		ST_DIV,
		ST_SIGN,
		ST_AVG,
		ST_OUT
	} state_t;

	function automatic logic [31:0] lfsr_next(input logic [31:0] r);
		logic [31:0] s;
		s = r >> 1;
		if (r[0]) begin
			s = s ^ LFSR_TAPS;
		end
		return s;
	endfunction

endpackage

// File: sv/pngu_req_if.sv
// ----------------------------------------------------------------------------
// Pink noise generator request channel
// One beat asks for one sample and carries the end-of-buffer mark.
// ----------------------------------------------------------------------------
interface pngu_req_if ();
	logic valid;
	logic ready;
	logic end_of_buffer;

	modport source (output valid, output end_of_buffer, input ready);
	modport sink (input valid, input end_of_buffer, output ready);
endinterface

// File: sv/pngu_smp_if.sv
// ----------------------------------------------------------------------------
// Pink noise generator sample channel
// One beat carries one signed sample and the copied end-of-buffer mark.
// ----------------------------------------------------------------------------
interface pngu_smp_if import pngu_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       buffer_last;

	modport source (output valid, output sample, output buffer_last, input ready);
	modport sink (input valid, input sample, input buffer_last, output ready);
endinterface

// File: sv/pink_noise_generator_unit.sv
// ----------------------------------------------------------------------------
// Pink noise generator
// Voss and Voss-McCartney pink noise, white noise in the other two modes. Generator values
// live in a small synchronous memory that is walked once per pink sample.
//
//   channel  dir  beat contents
//   req      in   end_of_buffer
//   rsp      out  sample, buffer_last
//   apb      in   mode, amplitude, generator count, seed at 0x0/0x4/0x8/0xC
//
// A pink sample passes from acceptance through the walk, a draw for each redrawn
// generator and the final average to the output register; white takes one draw.
// The one-bit-per-cycle shared divider (32 steps) is used for every draw and for
// the final average; the walk reads one generator per cycle between draws.
// Generators read as zero after reset through per-entry valid bits.
// A finished sample waits in the output register; a new request is taken
// while it waits, and the block stalls only if that register is still full.
// ----------------------------------------------------------------------------
module pink_noise_generator_unit import pngu_pkg::*; #(
	parameter int MAX_GENERATORS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	pngu_req_if.sink           req,
	pngu_smp_if.source         rsp
);

	localparam int GW    = (MAX_GENERATORS > 1) ? $clog2(MAX_GENERATORS) : 1;
	localparam int NW    = $clog2(MAX_GENERATORS + 1);
	localparam int SUM_W = SAMPLE_W + 1 + GW;

	state_t state_q, state_d;

	logic [MODE_W-1:0] mode_q;
	logic [AMP_W-1:0]  amp_q;
	logic [GCNT_W-1:0] gcnt_q;
	logic [31:0]       seed_q;
	logic [31:0]       lfsr_q;
	logic [31:0]       frame_q;

	logic signed [SAMPLE_W-1:0] mem [MAX_GENERATORS];
	logic [MAX_GENERATORS-1:0]  valid_q;
	logic signed [SAMPLE_W-1:0] rd_q;
	logic                       rdv_q;
	logic                       rd_en;
	logic [GW-1:0]              rd_addr;

	logic                      eob_q;
	logic                      white_q;
	logic [NW-1:0]             n_q;
	logic [MAX_GENERATORS-1:0] sel_q;
	logic [GW-1:0]             g_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic                      neg_q;
	logic                      avg_q;
	logic [15:0]               rem_q;
	logic [31:0]               quo_q;
	logic [4:0]                cnt_q;
	logic signed [SAMPLE_W-1:0] result_q;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       out_last_q;

	logic                       cfg_we;
	reg_idx_t                   cfg_idx;
	logic                       in_acc;
	logic                       in_white;
	logic [6:0]                 n_wide;
	logic [NW-1:0]              n_eff;
	logic [31:0]                limit;
	logic [31:0]                cnt_inc;
	logic [31:0]                cnt_nxt;
	logic [31:0]                sel_full;
	logic                       last_g;
	logic signed [SAMPLE_W-1:0] gv;
	logic [31:0]                lfsr_adv;
	logic [AMP_W-1:0]           divisor;
	logic [15:0]                div_t;
	logic                       div_ge;
	logic [15:0]                rem_n;
	logic [31:0]                quo_n;
	logic signed [SAMPLE_W-1:0] draw_val;
	logic signed [SAMPLE_W-1:0] avg_val;
	logic [SUM_W-1:0]           sum_abs;
	logic                       out_load;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_comb begin
		unique case (cfg_idx)
			REG_MODE: prdata = 32'(mode_q);
			REG_AMP:  prdata = 32'(amp_q);
			REG_GCNT: prdata = 32'(gcnt_q);
			REG_SEED: prdata = seed_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_VOSS;
			amp_q  <= AMP_RST;
			gcnt_q <= GCNT_RST;
			seed_q <= SEED_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODE: mode_q <= pwdata[MODE_W-1:0];
				REG_AMP:  amp_q  <= pwdata[AMP_W-1:0];
				REG_GCNT: gcnt_q <= pwdata[GCNT_W-1:0];
				REG_SEED: seed_q <= pwdata;
			endcase
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign in_acc    = req.valid && req.ready;
	assign in_white  = (mode_q != MODE_VOSS) && (mode_q != MODE_VM);

	always_comb begin
		priority if (gcnt_q == '0) begin
			n_wide = 7'd1;
		end else if (7'(gcnt_q) > 7'(MAX_GENERATORS)) begin
			n_wide = 7'(MAX_GENERATORS);
		end else begin
			n_wide = 7'(gcnt_q);
		end
	end

	assign n_eff    = n_wide[NW-1:0];
	assign limit    = 32'hFFFF_FFFF >> (7'd32 - n_wide);
	assign cnt_inc  = frame_q + 32'd1;
	assign cnt_nxt  = (cnt_inc > limit) ? 32'd0 : cnt_inc;
	assign sel_full = (mode_q == MODE_VOSS) ? (frame_q ^ cnt_nxt)
	                                        : (cnt_nxt & (~cnt_nxt + 32'd1));

	assign last_g   = (g_q == GW'(n_q - NW'(1)));
	assign gv       = rdv_q ? rd_q : '0;
	assign lfsr_adv = lfsr_next(lfsr_q);

	assign divisor  = avg_q ? AMP_W'(n_q) : ((amp_q == '0) ? AMP_W'(1) : amp_q);
	assign div_t    = {rem_q[14:0], quo_q[31]};
	assign div_ge   = (div_t >= {1'b0, divisor});
	assign rem_n    = div_ge ? (div_t - {1'b0, divisor}) : div_t;
	assign quo_n    = {quo_q[30:0], div_ge};

	assign draw_val = lfsr_adv[0] ? $signed({1'b0, rem_q[14:0]})
	                              : -$signed({1'b0, rem_q[14:0]});
	assign avg_val  = neg_q ? -$signed(quo_n[SAMPLE_W-1:0]) : $signed(quo_n[SAMPLE_W-1:0]);
	assign sum_abs  = (sum_q < 0) ? unsigned'(-sum_q) : unsigned'(sum_q);
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = GW'(g_q + 1'b1);
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (in_white) begin
						state_d = ST_DRAW;
					end else begin
						state_d = ST_WALK;
						rd_en   = 1'b1;
						rd_addr = '0;
					end
				end
			end
			ST_WALK: begin
				if (sel_q[g_q]) begin
					state_d = ST_DRAW;
				end else if (last_g) begin
					state_d = ST_AVG;
				end else begin
					rd_en = 1'b1;
				end
			end
			ST_DRAW: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = avg_q ? ST_OUT : ST_SIGN;
				end
			end
			ST_SIGN: begin
				if (white_q) begin
					state_d = ST_OUT;
				end else if (last_g) begin
					state_d = ST_AVG;
				end else begin
					state_d = ST_WALK;
					rd_en   = 1'b1;
				end
			end
			ST_AVG: state_d = ST_DIV;
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_SIGN) && !white_q) begin
			mem[g_q] <= draw_val;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rdv_q   <= 1'b0;
		end else begin
			if ((state_q == ST_SIGN) && !white_q) begin
				valid_q[g_q] <= 1'b1;
			end
			if (rd_en) begin
				rdv_q <= valid_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q  <= SEED_RST;
			frame_q <= '0;
		end else begin
			if (cfg_we && (cfg_idx == REG_SEED)) begin
				lfsr_q <= (pwdata == '0) ? 32'd1 : pwdata;
			end else if ((state_q == ST_DRAW) || (state_q == ST_SIGN)) begin
				lfsr_q <= lfsr_adv;
			end
			if (in_acc && !in_white) begin
				frame_q <= cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					eob_q   <= req.end_of_buffer;
					white_q <= in_white;
					n_q     <= n_eff;
					sel_q   <= sel_full[MAX_GENERATORS-1:0];
					g_q     <= '0;
					sum_q   <= '0;
				end
			end
			ST_WALK: begin
				if (!sel_q[g_q]) begin
					sum_q <= sum_q + SUM_W'(gv);
					if (!last_g) begin
						g_q <= GW'(g_q + 1'b1);
					end
				end
			end
			ST_DRAW: begin
				quo_q <= lfsr_adv;
				rem_q <= '0;
				cnt_q <= 5'd31;
				avg_q <= 1'b0;
			end
			ST_DIV: begin
				rem_q <= rem_n;
				quo_q <= quo_n;
				cnt_q <= cnt_q - 5'd1;
				if ((cnt_q == '0) && avg_q) begin
					result_q <= avg_val;
				end
			end
			ST_SIGN: begin
				if (white_q) begin
					result_q <= draw_val;
				end else begin
					sum_q <= sum_q + SUM_W'(draw_val);
					if (!last_g) begin
						g_q <= GW'(g_q + 1'b1);
					end
				end
			end
			ST_AVG: begin
				neg_q <= (sum_q < 0);
				quo_q <= 32'(sum_abs);
				rem_q <= '0;
				cnt_q <= 5'd31;
				avg_q <= 1'b1;
			end
			ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sample_q <= result_q;
			out_last_q   <= eob_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.sample      = out_sample_q;
	assign rsp.buffer_last = out_last_q;

	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.sample != {1'b1, {(SAMPLE_W-1){1'b0}}}))
		else $error("sample outside the symmetric range");

	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("random register locked at zero");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WALK) || ((state_q == ST_SIGN) && !white_q)) |->
		(NW'(g_q) < n_q))
		else $error("generator index beyond the generators in use");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while a sample is in progress");

endmodule

// File: sim/pink_noise_generator_unit_test.sv
// ----------------------------------------------------------------------------
// Pink noise generator unit test
// Requests samples under directed and random register settings and checks
// each sample against an in-bench model of the generator bank, frame counter
// and random shift register. Both channels idle at random between beats.
// ----------------------------------------------------------------------------
module pink_noise_generator_unit_test;
	import pngu_pkg::*;

	localparam int GEN_SLOTS = 32;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} noise_beat_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	pngu_req_if req_ch ();
	pngu_smp_if smp_ch ();

	pink_noise_generator_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (smp_ch)
	);

	mode_t                      cfg_mode;
	logic [AMP_W-1:0]           cfg_amplitude;
	logic [GCNT_W-1:0]          cfg_gen_count;
	logic [31:0]                frame_cnt;
	logic signed [SAMPLE_W-1:0] gen_val [GEN_SLOTS];
	logic [31:0]                noise_lfsr;

	noise_beat_t pending_samples [$];

	int  mismatch_count = 0;
	int  sent_count     = 0;
	int  checked_count  = 0;
	int  setting_count  = 0;
	bit  src_idle       = 1'b1;
	bit  sink_idle      = 1'b1;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 30) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
	endtask

	function automatic void reset_model();
		cfg_mode      = MODE_VOSS;
		cfg_amplitude = AMP_RST;
		cfg_gen_count = GCNT_RST;
		frame_cnt     = '0;
		for (int g = 0; g < GEN_SLOTS; g++) begin
			gen_val[g] = '0;
		end
		noise_lfsr = SEED_RST;
	endfunction

	function automatic logic [31:0] shift_noise();
		logic out_bit;
		out_bit = noise_lfsr[0];
		noise_lfsr = noise_lfsr >> 1;
		if (out_bit) begin
			noise_lfsr = noise_lfsr ^ LFSR_TAPS;
		end
		return noise_lfsr;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] draw_generator();
		logic [31:0] span;
		logic [31:0] magnitude;
		logic [31:0] sign_word;
		span = (cfg_amplitude == 0) ? 32'd1 : 32'(cfg_amplitude);
		magnitude = shift_noise() % span;
		sign_word = shift_noise();
		return sign_word[0] ? SAMPLE_W'(magnitude) : SAMPLE_W'(32'd0 - magnitude);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] predict_sample();
		int unsigned n;
		logic [31:0] limit;
		logic [31:0] last_cnt;
		logic [31:0] next_cnt;
		logic [31:0] toggled;
		int          sum;
		int          tz;
		if (cfg_mode != MODE_VOSS && cfg_mode != MODE_VM) begin
			return draw_generator();
		end
		n = (cfg_gen_count == 0) ? 1 : cfg_gen_count;
		if (n > GEN_SLOTS) begin
			n = GEN_SLOTS;
		end
		limit = 32'hFFFF_FFFF >> (32 - n);
		last_cnt = frame_cnt;
		next_cnt = last_cnt + 32'd1;
		if (next_cnt > limit) begin
			next_cnt = '0;
		end
		frame_cnt = next_cnt;
		if (cfg_mode == MODE_VOSS) begin
			toggled = last_cnt ^ next_cnt;
			for (int g = 0; g < n; g++) begin
				if (toggled[g]) begin
					gen_val[g] = draw_generator();
				end
			end
		end else begin
			tz = 0;
			while (tz < 32 && !next_cnt[tz]) begin
				tz++;
			end
			if (tz < n) begin
				gen_val[tz] = draw_generator();
			end
		end
		sum = 0;
		for (int g = 0; g < n; g++) begin
			sum += gen_val[g];
		end
		return SAMPLE_W'(sum / int'(n));
	endfunction

	task automatic apb_access(input logic wr, input reg_idx_t idx, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = PADDR_W'({idx, 2'b00});
		pwdata  = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic expect_register(input reg_idx_t idx, input logic [31:0] want);
		logic [31:0] got;
		apb_access(1'b0, idx, '0, got);
		if (got !== want) begin
			report_mismatch($sformatf("register %s reads %h, want %h", idx.name(), got, want));
		end
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] unused;
		logic [31:0] want;
		apb_access(1'b1, idx, value, unused);
		case (idx)
			REG_MODE: begin
				cfg_mode = mode_t'(value[MODE_W-1:0]);
				want = 32'(value[MODE_W-1:0]);
			end
			REG_AMP: begin
				cfg_amplitude = value[AMP_W-1:0];
				want = 32'(value[AMP_W-1:0]);
			end
			REG_GCNT: begin
				cfg_gen_count = value[GCNT_W-1:0];
				want = 32'(value[GCNT_W-1:0]);
			end
			default: begin
				noise_lfsr = (value == 0) ? 32'd1 : value;
				want = value;
			end
		endcase
		expect_register(idx, want);
	endtask

	task automatic send_request(input logic eob);
		int          gap;
		noise_beat_t next_beat;
		gap = src_idle ? $urandom_range(0, 3) : 0;
		@(negedge clk);
		if (gap != 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.end_of_buffer = eob;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		next_beat.sample = predict_sample();
		next_beat.last = eob;
		pending_samples.push_back(next_beat);
		sent_count++;
	endtask

	task automatic settle();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_samples.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic send_burst(input int count);
		for (int i = 0; i < count; i++) begin
			send_request(i[0]);
		end
		settle();
	endtask

	task automatic test_reset_values();
		expect_register(REG_MODE, 32'(MODE_VOSS));
		expect_register(REG_AMP, 32'(AMP_RST));
		expect_register(REG_GCNT, 32'(GCNT_RST));
		expect_register(REG_SEED, SEED_RST);
		send_burst(3);
	endtask

	task automatic test_counter_wrap();
		// The counter left at three by the default width wraps as soon as the width is one.
		write_reg(REG_GCNT, 32'd1);
		send_burst(1);
		write_reg(REG_MODE, 32'(MODE_VM));
		write_reg(REG_AMP, 32'd32767);
		send_burst(2);
	endtask

	task automatic test_white_modes();
		write_reg(REG_MODE, 32'(MODE_ALT));
		write_reg(REG_AMP, 32'd0);
		send_burst(2);
		write_reg(REG_MODE, 32'(MODE_WHITE));
		write_reg(REG_AMP, 32'd32767);
		write_reg(REG_SEED, 32'd0);
		send_burst(2);
		write_reg(REG_SEED, 32'hFFFF_FFFF);
		send_burst(1);
	endtask

	task automatic test_generator_count_limits();
		write_reg(REG_MODE, 32'(MODE_VOSS));
		write_reg(REG_AMP, 32'd1000);
		write_reg(REG_GCNT, 32'd0);
		send_burst(2);
		write_reg(REG_GCNT, 32'd63);
		send_burst(2);
		write_reg(REG_MODE, 32'(MODE_VM));
		write_reg(REG_GCNT, 32'd33);
		send_burst(2);
	endtask

	task automatic test_unused_generators();
		write_reg(REG_MODE, 32'(MODE_VOSS));
		write_reg(REG_AMP, 32'd32767);
		write_reg(REG_GCNT, 32'd4);
		send_burst(3);
		write_reg(REG_GCNT, 32'd2);
		send_burst(1);
		write_reg(REG_GCNT, 32'd4);
		send_burst(2);
	endtask

	task automatic test_random_settings();
		int          random_sent;
		int          burst;
		int          pick;
		logic [31:0] value;
		random_sent = 0;
		while (random_sent < 1800) begin
			setting_count++;
			pick = $urandom_range(0, 9);
			write_reg(REG_MODE, 32'((pick < 4) ? MODE_VOSS : (pick < 8) ? MODE_VM :
				(pick == 8) ? MODE_WHITE : MODE_ALT));
			case ($urandom_range(0, 5))
				0: value = 32'd0;
				1: value = 32'd1;
				2: value = 32'd32767;
				default: value = $urandom_range(2, 32766);
			endcase
			write_reg(REG_AMP, value);
			case ($urandom_range(0, 7))
				0: value = 32'd0;
				1: value = 32'd1;
				2: value = 32'd32;
				3: value = $urandom_range(33, 63);
				default: value = $urandom_range(2, 31);
			endcase
			write_reg(REG_GCNT, value);
			case ($urandom_range(0, 5))
				0: write_reg(REG_SEED, 32'd0);
				1: write_reg(REG_SEED, 32'hFFFF_FFFF);
				2, 3: write_reg(REG_SEED, $urandom);
				default: ;
			endcase
			pick = $urandom_range(0, 3);
			src_idle = (pick != 0) && $urandom_range(0, 4) != 0;
			sink_idle = (pick != 0) && $urandom_range(0, 4) != 0;
			burst = $urandom_range(20, 100);
			for (int i = 0; i < burst; i++) begin
				send_request($urandom_range(0, 7) == 0);
				random_sent++;
				if ($urandom_range(0, 59) == 0) begin
					settle();
				end
			end
			settle();
		end
		src_idle = 1'b1;
		sink_idle = 1'b1;
	endtask

	initial begin : sample_checker
		noise_beat_t want;
		int          stall;
		smp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = sink_idle ? $urandom_range(0, 3) : 0;
			@(negedge clk);
			if (stall != 0) begin
				smp_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			smp_ch.ready = 1'b1;
			do @(posedge clk); while (smp_ch.valid !== 1'b1);
			checked_count++;
			if (pending_samples.size() == 0) begin
				report_mismatch("sample beat with nothing expected");
			end else begin
				want = pending_samples.pop_front();
				if (smp_ch.sample !== want.sample) begin
					report_mismatch($sformatf("sample %0d, want %0d",
						smp_ch.sample, want.sample));
				end
				if (smp_ch.buffer_last !== want.last) begin
					report_mismatch($sformatf("buffer_last %b, want %b",
						smp_ch.buffer_last, want.last));
				end
			end
		end
	end

	initial begin
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		req_ch.valid = 1'b0;
		req_ch.end_of_buffer = 1'b0;
		reset_model();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_counter_wrap();
		test_white_modes();
		test_generator_count_limits();
		test_unused_generators();
		test_random_settings();

		settle();
		repeat (1300) @(posedge clk);
		if (pending_samples.size() != 0) begin
			report_mismatch("expected samples never arrived");
		end
		$display("%0d sample requests in all modes, %0d random register settings,",
			sent_count, setting_count);
		$display("%0d samples checked, %0d mismatches", checked_count, mismatch_count);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: files.f
sv/pngu_pkg.sv
sv/pngu_req_if.sv
sv/pngu_smp_if.sv
sv/pink_noise_generator_unit.sv
sim/pink_noise_generator_unit_test.sv
